[design/plde_pkg.sv]
// ----------------------------------------------------------------------------
// plde_pkg: shared types and constants for the positional list deque
// Element storage sizes, operation and status codes, cell command bundle.
// ----------------------------------------------------------------------------
package plde_pkg;

  localparam int CAPACITY = 64;
  localparam int ELEM_W   = 32;

  // Fixed field widths of the request and result items
  localparam int OPCODE_W = 3;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD_FRONT  = 3'd0,
    OP_ADD_REAR   = 3'd1,
    OP_REM_FRONT  = 3'd2,
    OP_REM_REAR   = 3'd3,
    OP_REM_AT     = 3'd4,
    OP_INS_BEFORE = 3'd5
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Broadcast to every cell: shift open a gap or close one at index at
  typedef struct packed {
    logic ins;
    logic del;
    idx_t at;
  } cell_cmd_t;

  // Keep the low ELEM_W bits of an incoming value
  function automatic elem_t to_elem(input logic [VALUE_W-1:0] v);
    logic [63:0] w;
    w = {32'b0, v};
    return w[ELEM_W-1:0];
  endfunction

  // Report an element in 32 bits, zero-extended or truncated
  function automatic logic [VALUE_W-1:0] to_word(input elem_t e);
    logic [63:0] w;
    w = 64'(e);
    return w[VALUE_W-1:0];
  endfunction

endpackage

[design/plde_cell.sv]
// ----------------------------------------------------------------------------
// plde_cell: one storage cell of the list
// Holds one element; loads from the left, the right or the new value.
// ----------------------------------------------------------------------------
module plde_cell
  import plde_pkg::*;
(
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  idx_t      my_idx,
  input  elem_t     left_data,
  input  elem_t     right_data,
  input  elem_t     ins_data,
  output elem_t     data,
  output elem_t     tap
);

  elem_t data_r;
  elem_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cmd.ins) begin
      if (my_idx > cmd.at) begin
        data_nxt = left_data;
      end else if (my_idx == cmd.at) begin
        data_nxt = ins_data;
      end
    end else if (cmd.del) begin
      if (my_idx >= cmd.at) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  // offer the current element when this cell is the one being removed
  assign tap  = (cmd.del && (my_idx == cmd.at)) ? data_r : '0;

endmodule

[design/plde_ctrl.sv]
// ----------------------------------------------------------------------------
// plde_ctrl: request decode and element count
// Checks bounds, picks the cell command and tracks the held count.
// ----------------------------------------------------------------------------
module plde_ctrl
  import plde_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [POS_W-1:0]    position,
  output cell_cmd_t           cmd,
  output status_t             status,
  output cnt_t                cnt_nxt,
  output cnt_t                held
);

  cnt_t             held_r;
  cnt_t             held_nxt;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] held_ext;
  logic             full;
  logic             empty;
  logic             ins;
  logic             del;
  idx_t             at;
  status_t          st;

  assign pos_ext  = CMP_W'(position);
  assign held_ext = CMP_W'(held_r);
  assign full     = (held_ext >= CMP_W'(CAPACITY));
  assign empty    = (held_r == '0);

  always_comb begin
    ins = 1'b0;
    del = 1'b0;
    at  = '0;
    st  = ST_OK;
    unique case (opcode)
      OP_ADD_FRONT: begin
        if (full) st = ST_FULL;
        else ins = 1'b1;
      end
      OP_ADD_REAR: begin
        if (full) st = ST_FULL;
        else begin
          ins = 1'b1;
          at  = held_r[IDX_W-1:0];
        end
      end
      OP_REM_FRONT: begin
        if (empty) st = ST_UNDERFLOW;
        else del = 1'b1;
      end
      OP_REM_REAR: begin
        if (empty) st = ST_UNDERFLOW;
        else begin
          del = 1'b1;
          at  = idx_t'(held_r - cnt_t'(1));
        end
      end
      OP_REM_AT: begin
        if (pos_ext == '0 || pos_ext > held_ext) st = ST_RANGE;
        else begin
          del = 1'b1;
          at  = idx_t'(pos_ext - CMP_W'(1));
        end
      end
      OP_INS_BEFORE: begin
        if (pos_ext == '0 || pos_ext > held_ext + CMP_W'(1)) st = ST_RANGE;
        else if (full) st = ST_FULL;
        else begin
          ins = 1'b1;
          at  = idx_t'(pos_ext - CMP_W'(1));
        end
      end
      default: begin
        // unused codes: no operation
      end
    endcase
  end

  always_comb begin
    held_nxt = held_r;
    if (accept && ins) held_nxt = held_r + cnt_t'(1);
    else if (accept && del) held_nxt = held_r - cnt_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else begin
      held_r <= held_nxt;
    end
  end

  assign cmd.ins = accept && ins;
  assign cmd.del = accept && del;
  assign cmd.at  = at;
  assign status  = st;
  assign cnt_nxt = held_nxt;
  assign held    = held_r;

endmodule

[design/positional_list_deque.sv]
// ----------------------------------------------------------------------------
// positional_list_deque: ordered list with end and positional add/remove
// A row of cells holds the list, front at cell 0; each accepted add or remove
// shifts the cells at and beyond the named index by one place.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata fields, lowest bit first
//  --------+-----+--------------------------------------------------------
//  in_     | in  | opcode[2:0], position[9:3], value[41:10], zero pad
//  out_    | out | status[1:0], removed_value[33:2], entry_count[40:34],
//          |     | is_empty[41], zero pad
//
//  Cycles: one request per cycle while out_tready drains the result; the result
//    appears in the output register the cycle after the request is accepted.
//  That rate comes from the cell row: every cell compares its
//    index with the request's index and loads its new element in parallel.
//  Reset: rst_n clears the element count and the output valid; cell contents
//    are undefined until written and are never read beyond the count.
//  Stalls: a new request is taken while the output register is empty or is
//    being drained in the same cycle; out_tready low holds the result.
//
module positional_list_deque
  import plde_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // opcode, position, value, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status, removed_value, entry_count, is_empty, pad
);

  logic [OPCODE_W-1:0] req_opcode;
  logic [POS_W-1:0]    req_position;
  logic [VALUE_W-1:0]  req_value;
  logic                accept;

  cell_cmd_t cmd;
  status_t   status;
  cnt_t      cnt_nxt;
  cnt_t      held;

  elem_t cell_q   [CAPACITY];
  elem_t cell_tap [CAPACITY];
  elem_t ins_elem;
  elem_t removed_elem;

  logic                out_valid_r;
  status_t             out_status_r;
  logic [VALUE_W-1:0]  out_removed_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                out_empty_r;

  // Unpack the request
  assign req_opcode   = in_tdata[2:0];
  assign req_position = in_tdata[9:3];
  assign req_value    = in_tdata[41:10];

  // Take a request whenever the result register is free or draining
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  plde_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .opcode   (req_opcode),
    .position (req_position),
    .cmd      (cmd),
    .status   (status),
    .cnt_nxt  (cnt_nxt),
    .held     (held)
  );

  assign ins_elem = to_elem(req_value);

  // Cell row: each cell sees its two neighbors; the ends see themselves
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    elem_t left_w;
    elem_t right_w;
    if (i == 0) begin : g_first
      assign left_w = cell_q[i];
    end else begin : g_left
      assign left_w = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_q[i];
    end else begin : g_right
      assign right_w = cell_q[i+1];
    end
    plde_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .my_idx     (idx_t'(i)),
      .left_data  (left_w),
      .right_data (right_w),
      .ins_data   (ins_elem),
      .data       (cell_q[i]),
      .tap        (cell_tap[i])
    );
  end

  // At most one cell offers a nonzero tap: merge them
  always_comb begin
    removed_elem = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      removed_elem = removed_elem | cell_tap[i];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r  <= status;
      out_removed_r <= to_word(removed_elem);
      out_count_r   <= COUNT_W'(cnt_nxt);
      out_empty_r   <= (cnt_nxt == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_empty_r, out_count_r, out_removed_r, out_status_r};

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(CAPACITY) >= held)
    else $error("element count above capacity");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(held))
    else $error("element count moved without a request");

  a_fail_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |-> (out_removed_r == '0))
    else $error("failed request reports a removed element");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_empty_r == (out_count_r == '0)))
    else $error("empty flag disagrees with count");

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the positional list deque
// Drives list requests over the in_ stream, takes the expected result from the
// directed table or a queue-based list model, and compares each out_ result
// field by field while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top
  import plde_pkg::*;
();

  // Opcodes the block treats as no-ops
  localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int N_DIRECTED  = 24;
  localparam int N_RANDOM    = 600;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    status_t              status;
    logic [VALUE_W-1:0]   removed;
    logic [COUNT_W-1:0]   count;
    logic                 empty;
  } deque_result_t;

  typedef struct {
    logic [OPCODE_W-1:0]  op;
    logic [POS_W-1:0]     pos;
    logic [VALUE_W-1:0]   val;
    bit                   typed;   // res holds the expected result as written
    deque_result_t        res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;     // opcode, position, value, zero pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;         // status, removed_value, entry_count, is_empty, pad

  // List contents as the block should hold them, front first
  logic [ELEM_W-1:0] list_q[$];
  // Results owed by the block, oldest first
  deque_result_t     owed_q[$];
  int unsigned       err_count = 0;

  // Directed requests; the first rows start from an empty list after reset
  stim_row_t directed_tbl [0:N_DIRECTED-1] = '{
    '{OP_REM_FRONT,  7'd0,  32'h0,         1'b1, '{ST_UNDERFLOW, 32'h0, 7'd0, 1'b1}},
    '{OP_REM_REAR,   7'd0,  32'h0,         1'b1, '{ST_UNDERFLOW, 32'h0, 7'd0, 1'b1}},
    '{OP_REM_AT,     7'd1,  32'h0,         1'b1, '{ST_RANGE,     32'h0, 7'd0, 1'b1}},
    '{OP_INS_BEFORE, 7'd0,  32'h1234_5678, 1'b1, '{ST_RANGE,     32'h0, 7'd0, 1'b1}},
    '{OP_INS_BEFORE, 7'd2,  32'h0000_0001, 1'b1, '{ST_RANGE,     32'h0, 7'd0, 1'b1}},
    '{OP_SPARE_6,    7'd65, 32'hFFFF_FFFF, 1'b1, '{ST_OK,        32'h0, 7'd0, 1'b1}},
    '{OP_SPARE_7,    7'd0,  32'h0,         1'b1, '{ST_OK,        32'h0, 7'd0, 1'b1}},
    '{OP_ADD_FRONT,  7'd0,  32'h7FFF_FFFF, 1'b1, '{ST_OK,        32'h0, 7'd1, 1'b0}},
    '{OP_ADD_REAR,   7'd65, 32'h8000_0000, 1'b1, '{ST_OK,        32'h0, 7'd2, 1'b0}},
    '{OP_INS_BEFORE, 7'd1,  32'hFFFF_FFFF, 1'b1, '{ST_OK,        32'h0, 7'd3, 1'b0}},
    '{OP_INS_BEFORE, 7'd4,  32'h0,         1'b1, '{ST_OK,        32'h0, 7'd4, 1'b0}},
    '{OP_INS_BEFORE, 7'd6,  32'h5555_5555, 1'b1, '{ST_RANGE,     32'h0, 7'd4, 1'b0}},
    '{OP_REM_AT,     7'd0,  32'h0,         1'b1, '{ST_RANGE,     32'h0, 7'd4, 1'b0}},
    '{OP_REM_AT,     7'd65, 32'h0,         1'b1, '{ST_RANGE,     32'h0, 7'd4, 1'b0}},
    '{OP_REM_AT,     7'd64, 32'h0,         1'b1, '{ST_RANGE,     32'h0, 7'd4, 1'b0}},
    '{OP_REM_AT,     7'd2,  32'h0,         1'b0, '{ST_OK,        32'h0, 7'd0, 1'b0}},
    '{OP_INS_BEFORE, 7'd2,  32'h5A5A_5A5A, 1'b0, '{ST_OK,        32'h0, 7'd0, 1'b0}},
    '{OP_REM_AT,     7'd4,  32'h0,         1'b0, '{ST_OK,        32'h0, 7'd0, 1'b0}},
    '{OP_REM_FRONT,  7'd0,  32'h0,         1'b0, '{ST_OK,        32'h0, 7'd0, 1'b0}},
    '{OP_REM_REAR,   7'd0,  32'h0,         1'b0, '{ST_OK,        32'h0, 7'd0, 1'b0}},
    '{OP_REM_AT,     7'd1,  32'h0,         1'b0, '{ST_OK,        32'h0, 7'd0, 1'b0}},
    '{OP_REM_REAR,   7'd0,  32'h0,         1'b0, '{ST_OK,        32'h0, 7'd0, 1'b0}},
    '{OP_INS_BEFORE, 7'd1,  32'hAAAA_AAAA, 1'b0, '{ST_OK,        32'h0, 7'd0, 1'b0}},
    '{OP_REM_AT,     7'd1,  32'h0,         1'b0, '{ST_OK,        32'h0, 7'd0, 1'b0}}
  };

  positional_list_deque i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  // Apply one request to the list copy and return the result it should give.
  // A failing request leaves the list as it was.
  function automatic deque_result_t apply_list_op(input logic [OPCODE_W-1:0] op,
                                                  input logic [POS_W-1:0]    pos,
                                                  input logic [VALUE_W-1:0]  val);
    deque_result_t r;
    int held;
    held      = list_q.size();
    r.status  = ST_OK;
    r.removed = '0;
    case (op)
      OP_ADD_FRONT, OP_ADD_REAR: begin
        if (held >= CAPACITY) r.status = ST_FULL;
        else if (op == OP_ADD_FRONT) list_q.push_front(val);
        else list_q.push_back(val);
      end
      OP_REM_FRONT, OP_REM_REAR: begin
        if (held == 0) r.status = ST_UNDERFLOW;
        else if (op == OP_REM_FRONT) r.removed = list_q.pop_front();
        else r.removed = list_q.pop_back();
      end
      OP_REM_AT: begin
        // empty list: every position is illegal, so range wins over underflow
        if (pos < 1 || pos > held) r.status = ST_RANGE;
        else begin
          r.removed = list_q[pos - 1];
          list_q.delete(pos - 1);
        end
      end
      OP_INS_BEFORE: begin
        // position is checked before the full condition
        if (pos < 1 || pos > held + 1) r.status = ST_RANGE;
        else if (held >= CAPACITY) r.status = ST_FULL;
        else list_q.insert(pos - 1, val);
      end
      default: ;
    endcase
    r.count = COUNT_W'(list_q.size());
    r.empty = (list_q.size() == 0);
    return r;
  endfunction

  // Offer one request and hold it until the block takes it; then log what the
  // block owes for it. in_tvalid stays high so a following request can go
  // out back to back.
  task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic [VALUE_W-1:0] val, input bit typed,
                              input deque_result_t typed_res);
    deque_result_t r;
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, val, pos, op};
    do @(posedge clk); while (!in_tready);
    r = apply_list_op(op, pos, val);
    owed_q.push_back(typed ? typed_res : r);
  endtask

  // Result side: check every accepted result and stall on a pattern that
  // switches between free flow, light stalls, heavy stalls and a periodic mask
  int unsigned ready_left = 0;
  int unsigned ready_mode = 0;
  int unsigned tick = 0;

  always @(posedge clk) begin
    deque_result_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status  = status_t'(out_tdata[1:0]);
        got.removed = out_tdata[33:2];
        got.count   = out_tdata[40:34];
        got.empty   = out_tdata[41];
        if (owed_q.size() == 0) begin
          err_count <= err_count + 1;
          if (err_count < MAX_REPORTS)
            $display("unexpected result: status %0d removed %h count %0d empty %0b",
                     got.status, got.removed, got.count, got.empty);
        end else begin
          want = owed_q.pop_front();
          if (got.status !== want.status || got.removed !== want.removed ||
              got.count !== want.count || got.empty !== want.empty) begin
            err_count <= err_count + 1;
            if (err_count < MAX_REPORTS)
              $display("mismatch: exp %0d %h %0d %0b, got %0d %h %0d %0b",
                       want.status, want.removed, want.count, want.empty,
                       got.status, got.removed, got.count, got.empty);
          end
        end
      end
      tick <= tick + 1;
      if (ready_left == 0) begin
        ready_mode <= $urandom_range(0, 3);
        ready_left <= $urandom_range(10, 60);
      end else begin
        ready_left <= ready_left - 1;
      end
      case (ready_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 3) != 0);
        2:       out_tready <= ($urandom_range(0, 5) == 0);
        default: out_tready <= (tick[1:0] != 2'b11);
      endcase
    end
  end

  // Request side: directed table, then random list traffic in bursts
  initial begin
    int unsigned   burst_left;
    int unsigned   held;
    int unsigned   roll;
    bit            fill_mode;
    bit            grow;
    logic [OPCODE_W-1:0] op;
    logic [POS_W-1:0]    pos;
    logic [VALUE_W-1:0]  val;
    deque_result_t       none;

    burst_left = 0;
    fill_mode  = 1'b1;
    none       = '{ST_OK, 32'h0, 7'd0, 1'b0};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED + N_RANDOM; i++) begin
      // drop valid for a random gap between bursts; some bursts run long
      if (burst_left == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 10);
      end
      burst_left--;

      // hold off once mid-run until the block has drained completely
      if (i == N_DIRECTED + N_RANDOM / 2) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (owed_q.size() != 0);
      end

      if (i < N_DIRECTED) begin
        send_request(directed_tbl[i].op, directed_tbl[i].pos, directed_tbl[i].val,
                     directed_tbl[i].typed, directed_tbl[i].res);
      end else begin
        // sweep the count between empty and full: grow until the list is
        // full and has refused a few adds, then shrink back to empty
        held = list_q.size();
        if (held == CAPACITY && $urandom_range(0, 5) == 0) fill_mode = 1'b0;
        else if (held == 0 && $urandom_range(0, 2) == 0) fill_mode = 1'b1;
        roll = $urandom_range(0, 99);
        grow = fill_mode ? (roll < 70) : (roll < 30);
        case ($urandom_range(0, 2))
          0:       op = grow ? OP_ADD_FRONT  : OP_REM_FRONT;
          1:       op = grow ? OP_ADD_REAR   : OP_REM_REAR;
          default: op = grow ? OP_INS_BEFORE : OP_REM_AT;
        endcase
        // mostly legal positions, sometimes any position from 0 to 65
        if ($urandom_range(0, 99) < 15 || (op == OP_REM_AT && held == 0))
          pos = POS_W'($urandom_range(0, 65));
        else if (op == OP_REM_AT)
          pos = POS_W'($urandom_range(1, held));
        else
          pos = POS_W'($urandom_range(1, held + 1));
        case ($urandom_range(0, 11))
          0:       val = 32'h8000_0000;
          1:       val = 32'h7FFF_FFFF;
          2:       val = 32'hFFFF_FFFF;
          3:       val = 32'h0;
          default: val = $urandom;
        endcase
        send_request(op, pos, val, 1'b0, none);
      end
    end

    in_tvalid <= 1'b0;
    while (owed_q.size() != 0) @(posedge clk);
    // let any stray result surface before judging
    repeat (10) @(posedge clk);
    if (err_count == 0 && owed_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[sim.f]
design/plde_pkg.sv
design/plde_cell.sv
design/plde_ctrl.sv
design/positional_list_deque.sv
tb/tb_top.sv
